// ===== hdl/semaphore_wait_queue_table_macros.svh =====
// assertion macros for the semaphore wait queue table
`ifndef SEMAPHORE_WAIT_QUEUE_TABLE_MACROS_SVH
`define SEMAPHORE_WAIT_QUEUE_TABLE_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define SWQ_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication checked outside reset
`define SWQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/swqt_pkg.sv =====
// ----------------------------------------------------------------------------
// swqt_pkg
// shared types and codes for the semaphore wait queue table
// ----------------------------------------------------------------------------
package swqt_pkg;

  localparam int DefMaxProcs = 32;
  localparam int KeyW        = 32;
  localparam int PidW        = 5;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_OUT    = 2'd2,
    REQ_PEEK   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_NONE = 2'd1,
    ST_FULL = 2'd2,
    ST_DUP  = 2'd3
  } status_t;

  // result of the key search over the descriptor keys
  typedef struct packed {
    logic       hit;
    logic       free_ok;
    logic [7:0] hit_idx;
    logic [7:0] free_idx;
  } match_t;

endpackage

// ===== hdl/swqt_match.sv =====
// ----------------------------------------------------------------------------
// swqt_match
// associative key search across descriptors, one entry per cycle
// ----------------------------------------------------------------------------
module swqt_match
  import swqt_pkg::*;
#(
  parameter int MaxProcs = DefMaxProcs,
  localparam int IdxW = (MaxProcs > 1) ? $clog2(MaxProcs) : 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            go,
  input  logic [KeyW-1:0] key,
  input  logic            wr_en,
  input  logic [IdxW-1:0] wr_idx,
  input  logic            wr_active,
  input  logic [KeyW-1:0] wr_key,
  output logic            done,
  output match_t          res
);

  logic [KeyW-1:0] key_mem [MaxProcs];
  logic [MaxProcs-1:0] active;
  logic [IdxW:0] cnt;
  logic running;
  logic [KeyW-1:0] rd_key;
  logic [IdxW-1:0] rd_idx;
  logic rd_vld;
  logic rd_act;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_idx] <= wr_key;
    end
    rd_key <= key_mem[cnt[IdxW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active  <= '0;
      running <= 1'b0;
      cnt     <= '0;
      rd_vld  <= 1'b0;
      done    <= 1'b0;
      res     <= '0;
    end else begin
      done <= 1'b0;
      if (wr_en) begin
        active[wr_idx] <= wr_active;
      end
      rd_vld <= running;
      rd_idx <= cnt[IdxW-1:0];
      rd_act <= active[cnt[IdxW-1:0]];
      if (go) begin
        running <= 1'b1;
        cnt     <= '0;
        res     <= '0;
      end else if (running) begin
        if (cnt == (IdxW+1)'(MaxProcs - 1)) begin
          running <= 1'b0;
        end
        cnt <= cnt + 1'b1;
      end
      if (rd_vld) begin
        if (rd_act && rd_key == key && key != '0 && !res.hit) begin
          res.hit     <= 1'b1;
          res.hit_idx <= 8'(rd_idx);
        end
        if (!rd_act && !res.free_ok) begin
          res.free_ok  <= 1'b1;
          res.free_idx <= 8'(rd_idx);
        end
        if (!running) begin
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== hdl/swqt_ctrl.sv =====
// ----------------------------------------------------------------------------
// swqt_ctrl
// request sequencer: reads, modifies and writes back the queue memories
// ----------------------------------------------------------------------------
module swqt_ctrl
  import swqt_pkg::*;
#(
  parameter int MaxProcs = DefMaxProcs,
  localparam int IdxW = (MaxProcs > 1) ? $clog2(MaxProcs) : 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [1:0]      req_type,
  input  logic [KeyW-1:0] sem_key,
  input  logic [PidW-1:0] proc_id,
  output logic            busy,
  output logic            strobe,
  output logic [1:0]      status,
  output logic [PidW-1:0] result_proc
);

  typedef enum logic [3:0] {
    S_IDLE, S_PKEY_RD, S_PKEY, S_SEARCH, S_DEC_RD, S_DECIDE, S_WALK_RD, S_WALK,
    S_NEXT_RD, S_NEXT, S_DONE
  } state_t;

  state_t state;
  req_t req;
  logic [KeyW-1:0] key;
  logic [IdxW-1:0] pid;
  logic pid_ok;
  logic [MaxProcs-1:0] queued;

  // per-descriptor head/tail and per-process next/key memories
  logic [IdxW-1:0] head_mem [MaxProcs];
  logic [IdxW-1:0] tail_mem [MaxProcs];
  logic [IdxW-1:0] next_mem [MaxProcs];
  logic [KeyW-1:0] pkey_mem [MaxProcs];
  logic [IdxW-1:0] d_addr, n_addr, p_addr;
  logic [IdxW-1:0] head_q, tail_q, next_q;
  logic [KeyW-1:0] pkey_q;

  logic go, m_done, m_wr;
  logic [IdxW-1:0] m_wr_idx;
  logic m_wr_act;
  logic [KeyW-1:0] m_wr_key;
  match_t m_res;
  logic [IdxW-1:0] d, cur, prev, hd, tl;
  logic [IdxW:0] steps;

  swqt_match #(.MaxProcs(MaxProcs)) u_match (
    .clk(clk), .rst(rst), .go(go), .key(key),
    .wr_en(m_wr), .wr_idx(m_wr_idx), .wr_active(m_wr_act), .wr_key(m_wr_key),
    .done(m_done), .res(m_res)
  );

  always_ff @(posedge clk) begin
    head_q <= head_mem[d_addr];
    tail_q <= tail_mem[d_addr];
    next_q <= next_mem[n_addr];
    pkey_q <= pkey_mem[p_addr];
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      queued <= '0;
      strobe <= 1'b0;
      go     <= 1'b0;
      m_wr   <= 1'b0;
    end else begin
      strobe <= 1'b0;
      go     <= 1'b0;
      m_wr   <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            req    <= req_t'(req_type);
            key    <= sem_key;
            pid    <= IdxW'(proc_id);
            pid_ok <= (32'(proc_id) < MaxProcs);
            p_addr <= IdxW'(proc_id);
            state  <= S_PKEY_RD;
          end
        end
        S_PKEY_RD: state <= S_PKEY;
        S_PKEY: begin
          // out looks up the key recorded for the process
          if (req == REQ_OUT) begin
            if (!pid_ok || !queued[pid]) begin
              status <= ST_NONE;
              state  <= S_DONE;
            end else begin
              key   <= pkey_q;
              go    <= 1'b1;
              state <= S_SEARCH;
            end
          end else if (key == '0 || (req == REQ_INSERT && !pid_ok)) begin
            status <= ST_NONE;
            state  <= S_DONE;
          end else if (req == REQ_INSERT && queued[pid]) begin
            status <= ST_DUP;
            state  <= S_DONE;
          end else begin
            go    <= 1'b1;
            state <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          if (m_done) begin
            d      <= IdxW'(m_res.hit_idx);
            d_addr <= IdxW'(m_res.hit_idx);
            state  <= S_DEC_RD;
          end
        end
        S_DEC_RD: state <= S_DECIDE;
        S_DECIDE: begin
          // head_q and tail_q hold the hit descriptor
          hd <= head_q;
          tl <= tail_q;
          if (!m_res.hit && req != REQ_INSERT) begin
            status <= ST_NONE;
            state  <= S_DONE;
          end else begin
            unique case (req)
              REQ_INSERT: begin
                if (m_res.hit) begin
                  next_mem[tail_q] <= pid;
                  tail_mem[d]      <= pid;
                  status <= ST_OK;
                end else if (!m_res.free_ok) begin
                  status <= ST_FULL;
                end else begin
                  m_wr     <= 1'b1;
                  m_wr_idx <= IdxW'(m_res.free_idx);
                  m_wr_act <= 1'b1;
                  m_wr_key <= key;
                  head_mem[IdxW'(m_res.free_idx)] <= pid;
                  tail_mem[IdxW'(m_res.free_idx)] <= pid;
                  status <= ST_OK;
                end
                if (m_res.hit || m_res.free_ok) begin
                  queued[pid]   <= 1'b1;
                  pkey_mem[pid] <= key;
                end
                state <= S_DONE;
              end
              REQ_PEEK: begin
                status      <= ST_OK;
                result_proc <= PidW'(head_q);
                state       <= S_DONE;
              end
              REQ_REMOVE: begin
                status      <= ST_OK;
                result_proc <= PidW'(head_q);
                n_addr      <= head_q;
                state       <= S_NEXT_RD;
              end
              default: begin
                cur    <= head_q;
                prev   <= head_q;
                n_addr <= head_q;
                steps  <= '0;
                state  <= S_WALK_RD;
              end
            endcase
          end
        end
        S_NEXT_RD: state <= S_NEXT;
        S_NEXT: begin
          // pop head, release descriptor if it was the last one
          if (hd == tl) begin
            m_wr     <= 1'b1;
            m_wr_idx <= d;
            m_wr_act <= 1'b0;
            m_wr_key <= '0;
          end else begin
            head_mem[d] <= next_q;
          end
          queued[hd]   <= 1'b0;
          pkey_mem[hd] <= '0;
          state <= S_DONE;
        end
        S_WALK_RD: state <= S_WALK;
        S_WALK: begin
          // next_q is next of cur
          if (cur == pid) begin
            status      <= ST_OK;
            result_proc <= PidW'(pid);
            if (hd == pid && tl == pid) begin
              m_wr     <= 1'b1;
              m_wr_idx <= d;
              m_wr_act <= 1'b0;
              m_wr_key <= '0;
            end else if (hd == pid) begin
              head_mem[d] <= next_q;
            end else begin
              next_mem[prev] <= next_q;
              if (tl == pid) begin
                tail_mem[d] <= prev;
              end
            end
            queued[pid]   <= 1'b0;
            pkey_mem[pid] <= '0;
            state <= S_DONE;
          end else if (cur == tl || steps == (IdxW+1)'(MaxProcs - 1)) begin
            status <= ST_NONE;
            state  <= S_DONE;
          end else begin
            prev   <= cur;
            cur    <= next_q;
            n_addr <= next_q;
            steps  <= steps + 1'b1;
            state  <= S_WALK_RD;
          end
        end
        S_DONE: begin
          strobe <= 1'b1;
          if (status != ST_OK || req == REQ_INSERT) begin
            result_proc <= '0;
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      if (state == S_IDLE && start) begin
        result_proc <= '0;
      end
    end
  end

endmodule

// ===== hdl/semaphore_wait_queue_table.sv =====
// ----------------------------------------------------------------------------
// semaphore_wait_queue_table
// table of semaphore descriptors, each a fifo of blocked process ids
// ----------------------------------------------------------------------------
// channel  direction  signals
// request  in         start/busy, req_type, sem_key, proc_id
// result   out        strobe, status, result_proc
//
// one request at a time; busy is high from the cycle after acceptance and
// drops in the cycle that carries the result strobe. the key search scans
// MaxProcs descriptors one per cycle; an out request also walks the queue
// entry by entry, and a request refused on its fields alone skips the search.
// synchronous reset clears all valid and queued bits at once; no sweep.
// the receiver cannot stall: the strobe lasts one cycle.
module semaphore_wait_queue_table
  import swqt_pkg::*;
#(
  parameter int MaxProcs = DefMaxProcs
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [1:0]      req_type,
  input  logic [KeyW-1:0] sem_key,
  input  logic [PidW-1:0] proc_id,
  output logic            busy,
  output logic            strobe,
  output logic [1:0]      status,
  output logic [PidW-1:0] result_proc
);

  swqt_ctrl #(.MaxProcs(MaxProcs)) u_ctrl (
    .clk(clk), .rst(rst), .start(start), .req_type(req_type),
    .sem_key(sem_key), .proc_id(proc_id), .busy(busy), .strobe(strobe),
    .status(status), .result_proc(result_proc)
  );

endmodule

// ===== hdl/swqt_checker.sv =====
// ----------------------------------------------------------------------------
// swqt_checker
// port-level checks on the request/result sequencing
// ----------------------------------------------------------------------------
`include "semaphore_wait_queue_table_macros.svh"

module swqt_checker
  import swqt_pkg::*;
(
  input logic            clk,
  input logic            rst,
  input logic            start,
  input logic            busy,
  input logic            strobe,
  input logic [1:0]      status,
  input logic [4:0]      result_proc
);

  `SWQ_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy, "busy not raised")
  `SWQ_ASSERT_IMPL(a_strobe_busy, clk, rst, strobe, busy == 1'b0, "strobe while busy")
  `SWQ_ASSERT_NEXT(a_strobe_one, clk, rst, strobe, !strobe, "strobe longer than a beat")
  `SWQ_ASSERT_IMPL(a_err_zero, clk, rst, strobe && status != ST_OK, result_proc == '0, "proc set on error")
  `SWQ_ASSERT_IMPL(a_fall_strobe, clk, rst, $fell(busy), strobe, "busy fell without result")

endmodule

bind semaphore_wait_queue_table swqt_checker u_swqt_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .strobe(strobe),
  .status(status), .result_proc(result_proc)
);

// ===== test/semaphore_wait_queue_table_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// semaphore_wait_queue_table_tb
// checks the wait queue table against a behavioural table of descriptors and
// per-process links; requests go in by start/busy, each strobe is compared
// ----------------------------------------------------------------------------
module semaphore_wait_queue_table_tb;
  import swqt_pkg::*;

  localparam int NP = DefMaxProcs;

  typedef struct packed {
    req_t            kind;
    logic [KeyW-1:0] key;
    logic [PidW-1:0] pid;
  } sem_req_t;

  typedef struct packed {
    status_t         st;
    logic [PidW-1:0] proc;
  } sem_ans_t;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            start = 1'b0;
  logic [1:0]      req_type = '0;
  logic [KeyW-1:0] sem_key = '0;
  logic [PidW-1:0] proc_id = '0;
  logic            busy, strobe;
  logic [1:0]      status;
  logic [PidW-1:0] result_proc;

  semaphore_wait_queue_table dut (
    .clk(clk), .rst(rst), .start(start), .req_type(req_type),
    .sem_key(sem_key), .proc_id(proc_id), .busy(busy), .strobe(strobe),
    .status(status), .result_proc(result_proc)
  );

  always #5 clk = ~clk;

  // mirror of the table
  logic [KeyW-1:0] m_dkey [NP];
  logic            m_dact [NP];
  logic [PidW-1:0] m_dhead [NP];
  logic [PidW-1:0] m_dtail [NP];
  logic [PidW-1:0] m_next [NP];
  logic [KeyW-1:0] m_pkey [NP];
  logic            m_pq [NP];

  sem_req_t pending_reqs[$];
  sem_ans_t expected_answers[$];
  int  errors = 0;
  bit  quiet_tail = 0;
  bit  hold_send = 0;

  function automatic int lookup_desc(logic [KeyW-1:0] key);
    if (key == '0) return -1;
    for (int i = 0; i < NP; i++)
      if (m_dact[i] && m_dkey[i] == key) return i;
    return -1;
  endfunction

  function automatic sem_ans_t apply_request(sem_req_t r);
    sem_ans_t a;
    int d, fi, steps;
    logic [PidW-1:0] h, cur, prv;
    bit found;
    a.st = ST_NONE;
    a.proc = '0;
    case (r.kind)
      REQ_INSERT: begin
        if (r.key == '0) a.st = ST_NONE;
        else if (m_pq[r.pid]) a.st = ST_DUP;
        else begin
          d = lookup_desc(r.key);
          if (d >= 0) begin
            m_next[m_dtail[d]] = r.pid;
            m_dtail[d] = r.pid;
            a.st = ST_OK;
          end else begin
            fi = -1;
            for (int i = NP - 1; i >= 0; i--)
              if (!m_dact[i]) fi = i;
            if (fi < 0) a.st = ST_FULL;
            else begin
              m_dact[fi] = 1'b1;
              m_dkey[fi] = r.key;
              m_dhead[fi] = r.pid;
              m_dtail[fi] = r.pid;
              a.st = ST_OK;
            end
          end
          if (a.st == ST_OK) begin
            m_pq[r.pid] = 1'b1;
            m_pkey[r.pid] = r.key;
            m_next[r.pid] = r.pid;
          end
        end
      end
      REQ_REMOVE, REQ_PEEK: begin
        d = lookup_desc(r.key);
        if (d >= 0) begin
          h = m_dhead[d];
          a.st = ST_OK;
          a.proc = h;
          if (r.kind == REQ_REMOVE) begin
            if (m_dtail[d] == h) begin
              m_dact[d] = 1'b0;
              m_dkey[d] = '0;
            end else m_dhead[d] = m_next[h];
            m_pq[h] = 1'b0;
            m_pkey[h] = '0;
          end
        end
      end
      default: begin
        if (m_pq[r.pid]) begin
          d = lookup_desc(m_pkey[r.pid]);
          if (d >= 0) begin
            cur = m_dhead[d];
            prv = cur;
            found = 0;
            for (steps = 0; steps < NP; steps++) begin
              if (cur == r.pid) begin
                found = 1;
                break;
              end
              if (cur == m_dtail[d]) break;
              prv = cur;
              cur = m_next[cur];
            end
            if (found) begin
              a.st = ST_OK;
              a.proc = r.pid;
              if (m_dhead[d] == r.pid && m_dtail[d] == r.pid) begin
                m_dact[d] = 1'b0;
                m_dkey[d] = '0;
              end else if (m_dhead[d] == r.pid) m_dhead[d] = m_next[r.pid];
              else begin
                m_next[prv] = m_next[r.pid];
                if (m_dtail[d] == r.pid) m_dtail[d] = prv;
              end
              m_pq[r.pid] = 1'b0;
              m_pkey[r.pid] = '0;
            end
          end
        end
      end
    endcase
    if (a.st != ST_OK) a.proc = '0;
    return a;
  endfunction

  // driver
  int gap = 0;
  always @(posedge clk) begin
    sem_req_t r;
    if (rst) begin
      start <= 1'b0;
    end else if (start && !busy) begin
      // beat taken this edge
      expected_answers.push_back(apply_request({req_t'(req_type), sem_key, proc_id}));
      start <= 1'b0;
      if (!quiet_tail && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 15);
    end else if (!start) begin
      if (gap > 0) gap--;
      else if (!hold_send && pending_reqs.size() > 0) begin
        r = pending_reqs.pop_front();
        req_type <= r.kind;
        sem_key <= r.key;
        proc_id <= r.pid;
        start <= 1'b1;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    sem_ans_t e;
    if (!rst && strobe) begin
      if (expected_answers.size() == 0) begin
        $display("%0t: unexpected result status %0d proc %0d", $time, status, result_proc);
        errors++;
      end else begin
        e = expected_answers.pop_front();
        if (status !== e.st) begin
          $display("%0t: status expected %0d actual %0d", $time, e.st, status);
          errors++;
        end
        if (result_proc !== e.proc) begin
          $display("%0t: result_proc expected %0d actual %0d", $time, e.proc, result_proc);
          errors++;
        end
      end
    end
  end

  function automatic logic [KeyW-1:0] pick_key(int pool);
    if ($urandom_range(0, 19) == 0) return $urandom();
    return 32'h1000_0000 + $urandom_range(1, pool);
  endfunction

  task automatic push_req(req_t k, logic [KeyW-1:0] key, logic [PidW-1:0] pid);
    pending_reqs.push_back({k, key, pid});
  endtask

  // sampled away from the active edge so driver and monitor have settled
  task automatic drain();
    while (pending_reqs.size() > 0 || start || expected_answers.size() > 0)
      @(negedge clk);
  endtask

  initial begin
    int pool;
    for (int i = 0; i < NP; i++) begin
      m_dkey[i] = '0; m_dact[i] = 0; m_dhead[i] = '0; m_dtail[i] = '0;
      m_next[i] = '0; m_pkey[i] = '0; m_pq[i] = 0;
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: zero key, unknown key, extremes, dup, fill table, out cases
    push_req(REQ_INSERT, '0, 5'd3);
    push_req(REQ_REMOVE, '0, 5'd0);
    push_req(REQ_PEEK, 32'hFFFF_FFFF, 5'd0);
    push_req(REQ_OUT, 32'h0, 5'd31);
    push_req(REQ_INSERT, 32'hFFFF_FFFF, 5'd31);
    push_req(REQ_INSERT, 32'hFFFF_FFFF, 5'd0);
    push_req(REQ_INSERT, 32'h5555_AAAA, 5'd31);
    push_req(REQ_INSERT, 32'hFFFF_FFFF, 5'd7);
    push_req(REQ_PEEK, 32'hFFFF_FFFF, 5'd0);
    push_req(REQ_OUT, 32'h0, 5'd0);
    push_req(REQ_OUT, 32'h0, 5'd7);
    push_req(REQ_REMOVE, 32'hFFFF_FFFF, 5'd0);
    push_req(REQ_REMOVE, 32'hFFFF_FFFF, 5'd0);
    push_req(REQ_OUT, 32'h0, 5'd31);
    for (int p = 0; p < NP; p++) push_req(REQ_INSERT, 32'h100 + p, p[PidW-1:0]);
    drain();
    // table full needs a new key and a free process; pid 0 is still queued, and an out of a lone entry frees its desc
    push_req(REQ_INSERT, 32'hAAAA_5555, 5'd0);
    push_req(REQ_OUT, 32'h0, 5'd1);
    push_req(REQ_INSERT, 32'h100, 5'd1);
    push_req(REQ_OUT, 32'h0, 5'd2);
    push_req(REQ_INSERT, 32'hAAAA_5555, 5'd2);
    for (int p = 0; p < NP; p++) push_req(REQ_OUT, 32'h0, p[PidW-1:0]);
    drain();

    // random: keys mostly drawn from a pool of 4 or 40 so queues grow deep
    for (int n = 0; n < 1650; n++) begin
      pool = (n % 400 < 200) ? 4 : 40;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: push_req(REQ_INSERT, pick_key(pool), PidW'($urandom_range(0, NP - 1)));
        4, 5: push_req(REQ_REMOVE, pick_key(pool), PidW'($urandom()));
        6, 7: push_req(REQ_OUT, $urandom(), PidW'($urandom_range(0, NP - 1)));
        default: push_req(REQ_PEEK, pick_key(pool), PidW'($urandom()));
      endcase
      if (n == 800) begin
        drain();
        hold_send = 1;
        repeat (20) @(posedge clk);
        hold_send = 0;
      end
      if (n == 1400) begin
        drain();
        quiet_tail = 1;
      end
    end
    drain();
    repeat (100) @(posedge clk);
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
